// ===== rtl/core/rppd_pkg.sv =====
// ----------------------------------------------------------------------------
// rppd_pkg
// Shared types, constants and small tables for the raw packet pixel decoder.
// ----------------------------------------------------------------------------
package rppd_pkg;

    // Fixed field and state widths
    localparam int BIT_POS_W  = 17;
    localparam int IDX_W      = 15;
    localparam int SPLIT_W    = 15;
    localparam int PRED_W     = 17;
    localparam int PIX_IDX_W  = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;

    // Byte index scramble of the backward reader
    localparam logic [BIT_POS_W-4:0] BYTE_XOR = 14'h3ff0;

    // Packet layout
    localparam int PIXELS_PER_PACKET = 14;
    localparam logic [PIX_IDX_W-1:0] LAST_PIXEL = PIX_IDX_W'(PIXELS_PER_PACKET - 1);
    localparam logic [PIX_IDX_W-1:0] LATE_PIXEL = 4'd11;
    localparam logic [1:0] SHIFT_DUE_U = 2'd2;
    localparam logic [2:0] SHIFT_MAX   = 3'd4;
    localparam logic [7:0] PRED_BIAS   = 8'h80;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SPLIT_OFFSET  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLAG_ZERO_BAD = 2'd1;

    // Input actions
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    // What a bit-reader take is for
    typedef enum logic [1:0] {
        TAKE_SHIFT,
        TAKE_DELTA,
        TAKE_NZ,
        TAKE_LOW
    } take_kind_t;

    typedef struct packed {
        logic       load;
        logic       start;
        logic       step_pos;
        logic       issue_read;
        logic       capture;
        logic       apply;
        logic       emit;
        take_kind_t kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic shift_due;
        logic nonz_cur;
        logic bits_nonzero;
        logic late_pixel;
        logic last_pixel;
        logic out_free;
    } dp_status_t;

    function automatic logic [3:0] take_count(take_kind_t kind);
        logic [3:0] n;
        case (kind)
            TAKE_SHIFT: n = 4'd2;
            TAKE_DELTA: n = 4'd8;
            TAKE_NZ:    n = 4'd8;
            TAKE_LOW:   n = 4'd4;
            default:    n = 4'd8;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] take_mask(take_kind_t kind);
        logic [7:0] m;
        case (kind)
            TAKE_SHIFT: m = 8'h03;
            TAKE_DELTA: m = 8'hff;
            TAKE_NZ:    m = 8'hff;
            TAKE_LOW:   m = 8'h0f;
            default:    m = 8'hff;
        endcase
        return m;
    endfunction

    // Shift codes 0..3 select shifts 0, 1, 2, 4
    function automatic logic [2:0] shift_of_code(logic [1:0] code);
        logic [2:0] s;
        case (code)
            2'd0:    s = 3'd0;
            2'd1:    s = 3'd1;
            2'd2:    s = 3'd2;
            2'd3:    s = 3'd4;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/rppd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rppd_ctrl
// Sequencer: accepts items and steps the datapath through each pixel's takes.
// ----------------------------------------------------------------------------
module rppd_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  rppd_pkg::dp_status_t  status,
    output rppd_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIX,
        ST_POS,
        ST_ADDR,
        ST_DATA,
        ST_APPLY,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    rppd_pkg::take_kind_t  kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= rppd_pkg::TAKE_NZ;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        cmd            = '0;
        cmd.kind       = kind_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == rppd_pkg::ACT_DECODE)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_PIX;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_PIX:
            begin
                if (status.shift_due)
                    kind_next = rppd_pkg::TAKE_SHIFT;
                else if (status.nonz_cur)
                    kind_next = rppd_pkg::TAKE_DELTA;
                else
                    kind_next = rppd_pkg::TAKE_NZ;
                state_next = ST_POS;
            end
            ST_POS:
            begin
                cmd.step_pos = 1'b1;
                state_next   = ST_ADDR;
            end
            ST_ADDR:
            begin
                cmd.issue_read = 1'b1;
                state_next     = ST_DATA;
            end
            ST_DATA:
            begin
                cmd.capture = 1'b1;
                state_next  = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply = 1'b1;
                case (kind_reg)
                    rppd_pkg::TAKE_SHIFT:
                    begin
                        kind_next  = status.nonz_cur ? rppd_pkg::TAKE_DELTA
                                                     : rppd_pkg::TAKE_NZ;
                        state_next = ST_POS;
                    end
                    rppd_pkg::TAKE_NZ:
                    begin
                        if (status.bits_nonzero || status.late_pixel)
                        begin
                            kind_next  = rppd_pkg::TAKE_LOW;
                            state_next = ST_POS;
                        end
                        else
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                    default:
                    begin
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.last_pixel ? ST_IDLE : ST_PIX;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("pixel emitted while output register is occupied");

    a_decode_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && action == rppd_pkg::ACT_DECODE) |=> !in_ready)
        else $error("input still ready after a decode item was accepted");

endmodule

// ===== rtl/core/rppd_datapath.sv =====
// ----------------------------------------------------------------------------
// rppd_datapath
// Block store, rotated backward bit reader, predictors and output register.
// ----------------------------------------------------------------------------
module rppd_datapath
#(
    parameter int BLOCK_BYTES = 16384
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [rppd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rppd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [7:0]                            data_byte,
    input  logic                                  block_start,
    input  rppd_pkg::ctrl_cmd_t                   cmd,
    output rppd_pkg::dp_status_t                  status,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [15:0]                           pixel_value,
    output logic                                  zero_bad,
    output logic                                  last_of_packet
);

    localparam int ADDR_W = $clog2(BLOCK_BYTES);
    localparam int CNT_W  = $clog2(BLOCK_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BLOCK_BYTES);
    localparam int IW = rppd_pkg::IDX_W;
    localparam int PW = rppd_pkg::PRED_W;
    localparam int BW = rppd_pkg::BIT_POS_W;

    logic [7:0] mem [BLOCK_BYTES];

    logic [rppd_pkg::SPLIT_W-1:0] split_offset_reg;
    logic                         flag_zero_bad_reg;
    logic [CNT_W-1:0]             bytes_loaded_reg, bytes_loaded_next;
    logic [BW-1:0]                bit_pos_reg, bit_pos_next;
    logic [IW-1:0]                s_reg, tail_reg;
    logic [IW-1:0]                len_ext, s_new;
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;

    logic [IW-1:0]     idx0, idx1, src0, src1;
    logic [7:0]        rd0_reg, rd1_reg;
    logic              ok0_reg, ok1_reg;
    logic [15:0]       word;
    logic [15:0]       shifted;
    logic [7:0]        bits_reg;

    logic [PW-1:0]     pred_reg [2];
    logic [7:0]        nonz_reg [2];
    logic [2:0]        sh_reg;
    logic [rppd_pkg::PIX_IDX_W-1:0] p_reg;
    logic [1:0]        u_reg;
    logic              c;
    logic [PW-1:0]     pred_cur, sub, low_mask, trimmed, pred_delta, pred_low;

    logic              out_valid_reg;
    logic [15:0]       pixel_value_reg;
    logic              zero_bad_reg;
    logic              last_reg;

    function automatic logic [IW-1:0] rotate_src(logic [IW-1:0] idx,
                                                 logic [IW-1:0] s,
                                                 logic [IW-1:0] tail);
        logic [IW-1:0] r;
        r = (idx < tail) ? (s + idx) : (idx - tail);
        return r;
    endfunction

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_offset_reg  <= '0;
            flag_zero_bad_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rppd_pkg::CFG_SPLIT_OFFSET:  split_offset_reg  <= cfg_data;
                rppd_pkg::CFG_FLAG_ZERO_BAD: flag_zero_bad_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Load counter and reader position
    always_comb
    begin
        bytes_loaded_next = bytes_loaded_reg;
        bit_pos_next      = bit_pos_reg;
        wr_en             = 1'b0;
        wr_addr           = bytes_loaded_reg[ADDR_W-1:0];
        if (cmd.load)
        begin
            if (block_start)
            begin
                bytes_loaded_next = CNT_W'(1);
                bit_pos_next      = '0;
                wr_en             = 1'b1;
                wr_addr           = '0;
            end
            else if (bytes_loaded_reg < CNT_FULL)
            begin
                bytes_loaded_next = bytes_loaded_reg + CNT_W'(1);
                wr_en             = 1'b1;
            end
        end
        if (cmd.step_pos)
            bit_pos_next = bit_pos_reg - BW'(rppd_pkg::take_count(cmd.kind));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_loaded_reg <= '0;
            bit_pos_reg      <= '0;
        end
        else
        begin
            bytes_loaded_reg <= bytes_loaded_next;
            bit_pos_reg      <= bit_pos_next;
        end
    end

    // Rotation bounds, latched once per packet
    assign len_ext = IW'(bytes_loaded_reg);
    assign s_new   = (split_offset_reg < len_ext) ? split_offset_reg : len_ext;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            s_reg    <= s_new;
            tail_reg <= len_ext - s_new;
        end
    end

    // Rotated byte addresses of the current window
    assign idx0 = {1'b0, bit_pos_reg[BW-1:3] ^ rppd_pkg::BYTE_XOR};
    assign idx1 = idx0 + IW'(1);
    assign src0 = rotate_src(idx0, s_reg, tail_reg);
    assign src1 = rotate_src(idx1, s_reg, tail_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= data_byte;
        if (cmd.issue_read)
        begin
            rd0_reg <= mem[src0[ADDR_W-1:0]];
            rd1_reg <= mem[src1[ADDR_W-1:0]];
            ok0_reg <= (idx0 < len_ext);
            ok1_reg <= (idx1 < len_ext);
        end
    end

    // Bytes beyond the loaded data read as zero
    assign word    = {ok1_reg ? rd1_reg : 8'h00, ok0_reg ? rd0_reg : 8'h00};
    assign shifted = word >> bit_pos_reg[2:0];

    // Predictor arithmetic
    assign c          = p_reg[0];
    assign pred_cur   = pred_reg[c];
    assign sub        = pred_cur - (PW'(rppd_pkg::PRED_BIAS) << sh_reg);
    assign low_mask   = (PW'(1) << sh_reg) - PW'(1);
    assign trimmed    = (sub[PW-1] || sh_reg == rppd_pkg::SHIFT_MAX) ? (sub & low_mask) : sub;
    assign pred_delta = trimmed + (PW'(bits_reg) << sh_reg);
    assign pred_low   = PW'({nonz_reg[c], bits_reg[3:0]});

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            bits_reg <= shifted[7:0] & rppd_pkg::take_mask(cmd.kind);
        if (cmd.start)
        begin
            pred_reg[0] <= '0;
            pred_reg[1] <= '0;
            nonz_reg[0] <= '0;
            nonz_reg[1] <= '0;
        end
        else if (cmd.apply)
        begin
            case (cmd.kind)
                rppd_pkg::TAKE_DELTA:
                begin
                    if (bits_reg != 8'h00)
                        pred_reg[c] <= pred_delta;
                end
                rppd_pkg::TAKE_NZ:  nonz_reg[c] <= bits_reg;
                rppd_pkg::TAKE_LOW: pred_reg[c] <= pred_low;
                default: ;
            endcase
        end
    end

    // Pixel counters and shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg  <= '0;
            u_reg  <= '0;
            sh_reg <= '0;
        end
        else if (cmd.start)
        begin
            p_reg  <= '0;
            u_reg  <= '0;
            sh_reg <= '0;
        end
        else
        begin
            if (cmd.apply && cmd.kind == rppd_pkg::TAKE_SHIFT)
                sh_reg <= rppd_pkg::shift_of_code(bits_reg[1:0]);
            if (cmd.emit)
            begin
                p_reg <= p_reg + rppd_pkg::PIX_IDX_W'(1);
                u_reg <= (u_reg == rppd_pkg::SHIFT_DUE_U) ? 2'd0 : u_reg + 2'd1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pixel_value_reg <= pred_cur[15:0];
            zero_bad_reg    <= flag_zero_bad_reg && (pred_cur[15:0] == 16'h0000);
            last_reg        <= (p_reg == rppd_pkg::LAST_PIXEL);
        end
    end

    assign out_valid      = out_valid_reg;
    assign pixel_value    = pixel_value_reg;
    assign zero_bad       = zero_bad_reg;
    assign last_of_packet = last_reg;

    assign status.shift_due    = (u_reg == rppd_pkg::SHIFT_DUE_U);
    assign status.nonz_cur     = (nonz_reg[c] != 8'h00);
    assign status.bits_nonzero = (bits_reg != 8'h00);
    assign status.late_pixel   = (p_reg > rppd_pkg::LATE_PIXEL);
    assign status.last_pixel   = (p_reg == rppd_pkg::LAST_PIXEL);
    assign status.out_free     = !out_valid_reg || out_ready;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_loaded_reg <= CNT_FULL)
        else $error("byte count ran past the store depth");

    a_shift_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (sh_reg == 3'd0 || sh_reg == 3'd1 || sh_reg == 3'd2 || sh_reg == 3'd4))
        else $error("shift register holds an unused value");

    a_zero_bad_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_bad) |-> (pixel_value == 16'h0000))
        else $error("zero flag raised on a nonzero pixel");

endmodule

// ===== rtl/core/raw_packet_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// raw_packet_pixel_decoder: load items are taken while idle; decode items run alone.
// Each bit take steps through position, address, memory read and apply; a pixel
// adds a pixel step and an emit step to its 1 to 3 takes, and each 14-pixel packet
// may also stall on a full output register. Reset clears the counters and
// config; the block store needs no clearing pass and is undefined until written.
// ----------------------------------------------------------------------------
module raw_packet_pixel_decoder
#(
    parameter int BLOCK_BYTES = 16384
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rppd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rppd_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Input items
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             action,
    input  logic [7:0]                       data_byte,
    input  logic                             block_start,
    // Result items
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [15:0]                      pixel_value,
    output logic                             zero_bad,
    output logic                             last_of_packet
);

    // Command and status between the sequencer and the datapath
    rppd_pkg::ctrl_cmd_t  cmd;
    rppd_pkg::dp_status_t status;

    // Register writes land in the config registers at the next edge, so the config side never stalls
    assign cfg_ready = 1'b1;

    // Sequencer: takes load items every cycle while idle, and walks a decode
    // item through its fourteen pixels, one bit take at a time. It holds a
    // finished pixel until the output register has room.
    rppd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: block store, rotation at the split offset, backward bit
    // reader, the two interleaved predictors and the output register that
    // parts the result side from the sequencer.
    rppd_datapath
    #(
        .BLOCK_BYTES (BLOCK_BYTES)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .data_byte      (data_byte),
        .block_start    (block_start),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pixel_value    (pixel_value),
        .zero_bad       (zero_bad),
        .last_of_packet (last_of_packet)
    );

endmodule
